// File: sv/ssmux_pkg.sv
// ----------------------------------------------------------------------------
// ssmux_pkg
// Shared constants, register indexes and the character font of the scrolling
// seven-segment marquee.
// ----------------------------------------------------------------------------
package ssmux_pkg;

  localparam int MESSAGE_DEPTH = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_FRAMES   = 1'd1;

  localparam logic [5:0] MESSAGE_LENGTH_RESET = 6'd31;
  localparam logic [7:0] DWELL_FRAMES_RESET   = 8'd20;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5a;

  typedef logic [6:0] seg_t;

  // Return the glyph of code, or keep last for codes outside the font.
  function automatic seg_t font_decode(logic [7:0] code, seg_t last);
    seg_t res;
    res = last;
    if (code == CHAR_SPACE) begin
      res = 7'h00;
    end else if (code >= CHAR_A && code <= CHAR_Z) begin
      unique case (5'(code - CHAR_A))
        5'd0:    res = 7'h77;
        5'd1:    res = 7'h7c;
        5'd2:    res = 7'h39;
        5'd3:    res = 7'h5e;
        5'd4:    res = 7'h79;
        5'd5:    res = 7'h71;
        5'd6:    res = 7'h6f;
        5'd7:    res = 7'h76;
        5'd8:    res = 7'h19;
        5'd9:    res = 7'h1e;
        5'd10:   res = 7'h7a;
        5'd11:   res = 7'h38;
        5'd12:   res = 7'h37;
        5'd13:   res = 7'h54;
        5'd14:   res = 7'h3f;
        5'd15:   res = 7'h73;
        5'd16:   res = 7'h67;
        5'd17:   res = 7'h50;
        5'd18:   res = 7'h6d;
        5'd19:   res = 7'h78;
        5'd20:   res = 7'h1c;
        5'd21:   res = 7'h3e;
        5'd22:   res = 7'h1d;
        5'd23:   res = 7'h70;
        5'd24:   res = 7'h6e;
        5'd25:   res = 7'h29;
        default: res = last;
      endcase
    end
    return res;
  endfunction

endpackage

// File: sv/scrolling_seven_segment_multiplexer.sv
// ----------------------------------------------------------------------------
// scrolling_seven_segment_multiplexer
// Four-digit multiplexed seven-segment marquee that scrolls a message ring.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid/tready          tuser: action; tdata: slot, code, buttons
//   m_axis   out  tvalid/tready          tdata: digit select, segments, position
//   cfg      in   cfg_we_i               cfg_index_i, cfg_data_i
//
// One transaction per cycle while s_axis_tready is high; a tick result passes
// the message memory read at acceptance, then the output register, before it
// is offered. Loads give no result.
// Reset initialises all control state; unwritten message entries read as spaces.
// A stalled output holds one result and one more in the read stage, then
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module scrolling_seven_segment_multiplexer #(
  parameter int MessageDepth = ssmux_pkg::MESSAGE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] char_slot, [12:5] char_code, [13] button_forward,
  // [14] button_backward, [15] zero
  input  logic [15:0]                       s_axis_tdata,
  // [0] action
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] digit_select, [10:4] segments, [15:11] scroll_position
  output logic [15:0]                       m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [ssmux_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ssmux_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AddrW = $clog2(MessageDepth);
  localparam int RingTop = (MessageDepth < 32) ? MessageDepth : 32;
  localparam logic [5:0] RingTopW = 6'(RingTop);
  localparam logic [8:0] DepthW = 9'(MessageDepth);

  // Reduce v modulo len for v below eight times len.
  function automatic logic [5:0] mod_ring(logic [5:0] v, logic [5:0] len);
    logic [7:0] r;
    r = {2'd0, v};
    if (r >= {len, 2'd0}) begin
      r = r - {len, 2'd0};
    end
    if (r >= {1'b0, len, 1'b0}) begin
      r = r - {1'b0, len, 1'b0};
    end
    if (r >= {2'd0, len}) begin
      r = r - {2'd0, len};
    end
    return r[5:0];
  endfunction

  logic [5:0]  msg_len_q;
  logic [7:0]  dwell_frames_q;
  logic [4:0]  pos_q, pos_d;
  logic [1:0]  digit_q, digit_d;
  logic [11:0] dwell_cnt_q, dwell_cnt_d;
  logic        long_q, long_d;
  logic        back_q, back_d;
  ssmux_pkg::seg_t last_seg_q, seg_d;

  logic        s1_valid_q;
  logic [3:0]  s1_dsel_q;
  logic [4:0]  s1_pos_q;
  logic        out_valid_q;
  logic [15:0] out_data_q;

  logic        in_acc, tick_acc, load_acc, s1_adv;
  logic [4:0]  slot;
  logic [7:0]  code;
  logic        btn_fwd, btn_bwd;
  logic [5:0]  ring_len, pos_mod, idx_sum, idx;
  logic [7:0]  frames;
  logic [11:0] dwell_len, cnt_inc;
  logic [5:0]  pos_next;
  logic [8:0]  wr_ext, rd_ext;
  logic        wr_en;
  logic [7:0]  rd_data;

  assign slot    = s_axis_tdata[4:0];
  assign code    = s_axis_tdata[12:5];
  assign btn_fwd = s_axis_tdata[13];
  assign btn_bwd = s_axis_tdata[14];

  assign s1_adv        = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign tick_acc      = in_acc & ~s_axis_tuser;
  assign load_acc      = in_acc & s_axis_tuser;

  always_comb begin
    priority if (msg_len_q < 6'd4) begin
      ring_len = 6'd4;
    end else if (msg_len_q > RingTopW) begin
      ring_len = RingTopW;
    end else begin
      ring_len = msg_len_q;
    end

    back_d = back_q;
    long_d = long_q;
    if (dwell_cnt_q == '0) begin
      if (btn_fwd) back_d = 1'b0;
      if (btn_bwd) back_d = 1'b1;
      long_d = btn_fwd | btn_bwd;
    end

    digit_d = digit_q + 2'd1;
    pos_mod = mod_ring({1'b0, pos_q}, ring_len);
    idx_sum = pos_mod + {4'd0, digit_d};
    idx     = (idx_sum >= ring_len) ? idx_sum - ring_len : idx_sum;

    frames    = (dwell_frames_q == '0) ? 8'd1 : dwell_frames_q;
    dwell_len = long_d ? ({2'd0, frames, 2'd0} + {1'b0, frames, 3'd0})
                       : {2'd0, frames, 2'd0};
    cnt_inc   = dwell_cnt_q + 12'd1;

    if (back_d) begin
      pos_next = (pos_mod == '0) ? ring_len - 6'd1 : pos_mod - 6'd1;
    end else begin
      pos_next = (pos_mod + 6'd1 == ring_len) ? 6'd0 : pos_mod + 6'd1;
    end

    pos_d       = pos_q;
    dwell_cnt_d = cnt_inc;
    if (cnt_inc >= dwell_len) begin
      dwell_cnt_d = '0;
      pos_d       = pos_next[4:0];
    end
  end

  assign wr_ext = {4'd0, slot};
  assign rd_ext = {3'd0, idx};
  assign wr_en  = load_acc & (wr_ext < DepthW);

  ssmux_msg_store #(
    .MessageDepth(MessageDepth)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_ext[AddrW-1:0]),
    .wr_data_i (code),
    .rd_en_i   (tick_acc),
    .rd_addr_i (rd_ext[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  assign seg_d = ssmux_pkg::font_decode(rd_data, last_seg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q      <= ssmux_pkg::MESSAGE_LENGTH_RESET;
      dwell_frames_q <= ssmux_pkg::DWELL_FRAMES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssmux_pkg::CFG_MESSAGE_LENGTH: msg_len_q      <= cfg_data_i[5:0];
        ssmux_pkg::CFG_DWELL_FRAMES:   dwell_frames_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      digit_q     <= '0;
      dwell_cnt_q <= '0;
      long_q      <= 1'b0;
      back_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      last_seg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_acc) begin
        pos_q       <= pos_d;
        digit_q     <= digit_d;
        dwell_cnt_q <= dwell_cnt_d;
        long_q      <= long_d;
        back_q      <= back_d;
      end
      if (tick_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        last_seg_q  <= seg_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_dsel_q <= 4'b0001 << digit_d;
      s1_pos_q  <= pos_q;
    end
    if (s1_adv) begin
      out_data_q <= {s1_pos_q, seg_d, s1_dsel_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/ssmux_msg_store.sv
// ----------------------------------------------------------------------------
// ssmux_msg_store
// Message character memory: one write port, one registered read port, and a
// valid bit per entry so that unwritten entries read as a space.
// ----------------------------------------------------------------------------
module ssmux_msg_store #(
  parameter int MessageDepth = ssmux_pkg::MESSAGE_DEPTH,
  localparam int AddrW = $clog2(MessageDepth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]              mem_q [MessageDepth];
  logic [MessageDepth-1:0] valid_q;
  logic [7:0]              rd_data_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : ssmux_pkg::CHAR_SPACE;

endmodule

// File: sv/ssmux_checker.sv
// ----------------------------------------------------------------------------
// ssmux_checker
// Port-level checks of the scrolling marquee, bound to the top level.
// ----------------------------------------------------------------------------
module ssmux_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[3:0]))
    else $error("digit select not one-hot");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled output");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
      ##1 !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("load transaction produced a result");

endmodule

bind scrolling_seven_segment_multiplexer ssmux_checker u_ssmux_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the scrolling seven-segment marquee. Load and tick
// transactions are driven with random gaps, and a local model of the message
// ring, digit counter, dwell timer and scroll direction predicts every tick
// result. Results are compared field by field in order. The run steps through
// several ring lengths and dwell settings, the extremes included.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int STORE_DEPTH = 32;

  localparam logic [6:0] GLYPH [26] = '{
    7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71, 7'h6f, 7'h76, 7'h19, 7'h1e, 7'h7a,
    7'h38, 7'h37, 7'h54, 7'h3f, 7'h73, 7'h67, 7'h50, 7'h6d, 7'h78, 7'h1c, 7'h3e,
    7'h1d, 7'h70, 7'h6e, 7'h29
  };

  typedef struct packed {
    logic       action;
    logic [4:0] slot;
    logic [7:0] code;
    logic       fwd;
    logic       bwd;
  } marquee_item_t;

  typedef struct packed {
    logic [4:0]      pos;
    ssmux_pkg::seg_t seg;
    logic [3:0]      digit;
  } marquee_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [ssmux_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [ssmux_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  scrolling_seven_segment_multiplexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  marquee_item_t item_backlog[$];
  marquee_view_t display_expect[$];

  logic [7:0] msg_mem [STORE_DEPTH];
  logic [4:0] scroll_pos;
  logic [1:0] digit_cnt;
  logic [11:0] dwell_ticks;
  logic long_dwell;
  logic backward;
  ssmux_pkg::seg_t prev_seg;
  logic [5:0] cfg_len;
  logic [7:0] cfg_frames;

  logic in_taken = 1'b0;
  logic steady = 1'b0;
  int send_gap = 0;
  int rx_stall = 0;
  int rx_hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  marquee_item_t cur_item;
  marquee_view_t seen_view;
  marquee_view_t want_view;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40) begin
      $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic marquee_predict(marquee_item_t it);
    int len;
    int frames;
    int dwell_len;
    int idx;
    logic [7:0] ch;
    ssmux_pkg::seg_t seg;
    if (it.action) begin
      msg_mem[it.slot] = it.code;
      return;
    end
    len = int'(cfg_len);
    if (len < 4) len = 4;
    if (len > STORE_DEPTH) len = STORE_DEPTH;
    if (dwell_ticks == 0) begin
      if (it.fwd) backward = 1'b0;
      if (it.bwd) backward = 1'b1;
      long_dwell = it.fwd | it.bwd;
    end
    digit_cnt = digit_cnt + 2'd1;
    idx = (int'(scroll_pos) + int'(digit_cnt)) % len;
    ch = msg_mem[idx];
    if (ch >= ssmux_pkg::CHAR_A && ch <= ssmux_pkg::CHAR_Z) seg = GLYPH[ch - ssmux_pkg::CHAR_A];
    else if (ch == ssmux_pkg::CHAR_SPACE) seg = 7'h00;
    else seg = prev_seg;
    prev_seg = seg;
    display_expect.push_back('{digit: 4'(1 << digit_cnt), seg: seg, pos: scroll_pos});
    frames = (cfg_frames == 0) ? 1 : int'(cfg_frames);
    dwell_len = frames * 4 * (long_dwell ? 3 : 1);
    dwell_ticks = dwell_ticks + 12'd1;
    if (int'(dwell_ticks) >= dwell_len) begin
      dwell_ticks = '0;
      if (backward) scroll_pos = 5'((int'(scroll_pos) + len - 1) % len);
      else scroll_pos = 5'((int'(scroll_pos) + 1) % len);
    end
  endtask

  task automatic push_tick(logic fwd, logic bwd);
    item_backlog.push_back('{action: 1'b0, slot: 5'($urandom_range(0, 31)),
                             code: 8'($urandom_range(0, 255)), fwd: fwd, bwd: bwd});
  endtask

  task automatic push_load(logic [4:0] slot, logic [7:0] code);
    item_backlog.push_back('{action: 1'b1, slot: slot, code: code,
                             fwd: 1'($urandom_range(0, 1)), bwd: 1'($urandom_range(0, 1))});
  endtask

  function automatic marquee_item_t random_item();
    marquee_item_t it;
    int roll;
    it.action = ($urandom_range(0, 9) < 3);
    it.slot = 5'($urandom_range(0, 31));
    roll = $urandom_range(0, 9);
    if (roll < 6) it.code = ssmux_pkg::CHAR_A + 8'($urandom_range(0, 25));
    else if (roll < 8) it.code = ssmux_pkg::CHAR_SPACE;
    else it.code = 8'($urandom_range(0, 255));
    it.fwd = ($urandom_range(0, 99) < 15);
    it.bwd = ($urandom_range(0, 99) < 15);
    return it;
  endfunction

  task automatic wait_idle();
    while (item_backlog.size() != 0 || s_axis_tvalid || display_expect.size() != 0) begin
      @(posedge clk_i);
    end
    // settle before touching the registers
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ssmux_pkg::CFG_INDEX_W-1:0] index,
                           logic [ssmux_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    if (index == ssmux_pkg::CFG_MESSAGE_LENGTH) cfg_len = data[5:0];
    else cfg_frames = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [5:0] len, logic [7:0] frames);
    wait_idle();
    write_reg(ssmux_pkg::CFG_MESSAGE_LENGTH, ssmux_pkg::CFG_DATA_W'(len));
    write_reg(ssmux_pkg::CFG_DWELL_FRAMES, frames);
  endtask

  task automatic run_phase(logic [5:0] len, logic [7:0] frames, int count,
                           logic no_idle, int hold_cycles);
    configure(len, frames);
    steady = no_idle;
    if (hold_cycles > 0) begin
      @(posedge clk_i);
      rx_hold_left = hold_cycles;
    end
    repeat (count) item_backlog.push_back(random_item());
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          s_axis_tuser <= cur_item.action;
          s_axis_tdata <= {1'b0, cur_item.bwd, cur_item.fwd, cur_item.code, cur_item.slot};
          s_axis_tvalid <= 1'b1;
          send_gap = steady ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        rx_stall = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        marquee_predict('{action: s_axis_tuser, slot: s_axis_tdata[4:0],
                          code: s_axis_tdata[12:5], fwd: s_axis_tdata[13],
                          bwd: s_axis_tdata[14]});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_view = m_axis_tdata;
        if (display_expect.size() == 0) begin
          report_mismatch("unexpected result", int'(m_axis_tdata), 0);
        end else begin
          want_view = display_expect.pop_front();
          if (seen_view.digit !== want_view.digit)
            report_mismatch("digit_select", int'(seen_view.digit), int'(want_view.digit));
          if (seen_view.seg !== want_view.seg)
            report_mismatch("segments", int'(seen_view.seg), int'(want_view.seg));
          if (seen_view.pos !== want_view.pos)
            report_mismatch("scroll_position", int'(seen_view.pos), int'(want_view.pos));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) msg_mem[i] = ssmux_pkg::CHAR_SPACE;
    scroll_pos = '0;
    digit_cnt = '0;
    dwell_ticks = '0;
    long_dwell = 1'b0;
    backward = 1'b0;
    prev_seg = '0;
    cfg_len = ssmux_pkg::MESSAGE_LENGTH_RESET;
    cfg_frames = ssmux_pkg::DWELL_FRAMES_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // both buttons at dwell start, then glyphs, lowercase and codes outside the font
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_load(5'd0, "A");
    push_load(5'd1, "Z");
    push_load(5'd2, "a");
    push_load(5'd3, " ");
    push_load(5'd31, 8'hff);
    push_load(5'd4, 8'h00);
    repeat (4) push_tick(1'b0, 1'b0);

    // ring length and dwell below range
    configure(6'd0, 8'd0);
    repeat (6) push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);

    run_phase(6'd32, 8'd1, 140, 1'b0, 0);
    run_phase(6'd4, 8'd2, 130, 1'b0, 0);
    run_phase(6'd63, 8'd1, 130, 1'b0, 300);
    run_phase(6'd3, 8'd3, 120, 1'b0, 0);
    run_phase(6'd17, 8'd255, 100, 1'b0, 0);
    run_phase(6'd33, 8'd2, 120, 1'b0, 0);
    run_phase(6'd4, 8'd1, 120, 1'b1, 0);
    run_phase(6'd20, 8'd5, 120, 1'b0, 0);
    repeat (3) begin
      run_phase(6'($urandom_range(0, 63)), 8'($urandom_range(1, 6)), 100, 1'b0, 0);
    end

    while (item_backlog.size() != 0 || s_axis_tvalid || display_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (display_expect.size() != 0) begin
      report_mismatch("results missing", 0, display_expect.size());
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
